// File: rtl/core/pva_pkg.sv
// Shared types and constants for the priority voice allocator.
// Used by every module under rtl/core; depends on nothing else.
package pva_pkg;

  // Number of playback channels in the table.
  localparam int NUM_CHANNELS = 2;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  localparam int SND_W  = 8;
  localparam int POS_W  = 24;
  localparam int PRIO_W = 8;
  localparam int TICK_W = 16;
  localparam int CHO_W  = 4;
  localparam int SAVE_W = PRIO_W + POS_W + POS_W + SND_W;

  localparam logic [7:0] NUM_SOUNDS_RST = 8'd13;

  typedef logic [CH_W-1:0] ch_idx_t;

  typedef enum logic [2:0] {
    OP_PLAY    = 3'd0,
    OP_TICK    = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_SAVE    = 3'd3,
    OP_RESTORE = 3'd4
  } pva_op_e;

  typedef enum logic [2:0] {
    TW_PLAY    = 3'd0,
    TW_ADV     = 3'd1,
    TW_CLEAR   = 3'd2,
    TW_SAVE    = 3'd3,
    TW_RESTORE = 3'd4
  } tbl_op_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_PLACE = 6'b000100,
    S_TICK  = 6'b001000,
    S_BULK  = 6'b010000,
    S_RESP  = 6'b100000
  } pva_state_e;

  typedef struct packed {
    logic [2:0]        op;
    logic [SND_W-1:0]  sound_id;
    logic [PRIO_W-1:0] priority_req;
    logic [POS_W-1:0]  sound_length;
    logic [TICK_W-1:0] tick_bytes;
  } pva_in_t;

  typedef struct packed {
    logic              accepted;
    logic [CHO_W-1:0]  channel;
    logic [SND_W-1:0]  out_sound;
    logic [POS_W-1:0]  read_position;
    logic [TICK_W-1:0] amount;
    logic              last;
  } pva_out_t;

  // One channel as read from the table.
  typedef struct packed {
    logic [SND_W-1:0]  sound;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  len;
    logic [PRIO_W-1:0] prio;
  } pva_chan_t;

  // Write command from the sequencer to the table.
  typedef struct packed {
    logic              en;
    tbl_op_e           op;
    ch_idx_t           addr;
    logic [SND_W-1:0]  sound;
    logic [POS_W-1:0]  len;
    logic [POS_W-1:0]  pos;
    logic [PRIO_W-1:0] prio;
  } tbl_wr_t;

  // Results of the shared per-channel unit.
  typedef struct packed {
    logic              left_zero;
    logic [POS_W-1:0]  left;
    logic [TICK_W-1:0] amount;
    logic [POS_W-1:0]  next_pos;
    logic              better;
  } pva_step_t;

endpackage

// File: rtl/core/pva_step_unit.sv
// Shared per-channel arithmetic: bytes remaining, tick amount, advanced
// position and the lowest-priority comparison. Depends on pva_pkg.
module pva_step_unit (
  input  pva_pkg::pva_chan_t           chan_i,
  input  logic [pva_pkg::TICK_W-1:0]   tick_i,
  input  logic [pva_pkg::PRIO_W-1:0]   min_val_i,
  input  logic [pva_pkg::POS_W-1:0]    min_diff_i,
  input  logic                         first_i,
  output pva_pkg::pva_step_t           step_o
);
  import pva_pkg::*;

  logic [POS_W-1:0] left;
  logic [TICK_W-1:0] amount;

  assign left = (chan_i.pos >= chan_i.len) ? '0 : (chan_i.len - chan_i.pos);
  assign amount = (left > POS_W'(tick_i)) ? tick_i : left[TICK_W-1:0];

  assign step_o.left_zero = (left == '0);
  assign step_o.left      = left;
  assign step_o.amount    = amount;
  assign step_o.next_pos  = chan_i.pos + POS_W'(amount);
  // The first channel visited always sets the running minimum.
  assign step_o.better    = first_i || (chan_i.prio < min_val_i) ||
                            ((chan_i.prio == min_val_i) && (left < min_diff_i));

endmodule

// File: rtl/core/pva_chan_table.sv
// Channel table and its saved copy, one write port and one read port.
// Depends on pva_pkg.
module pva_chan_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pva_pkg::tbl_wr_t    wr_i,
  input  pva_pkg::ch_idx_t    rd_idx_i,
  output pva_pkg::pva_chan_t  rd_o
);
  import pva_pkg::*;

  logic [SND_W-1:0]  sound_q [NUM_CHANNELS];
  logic [POS_W-1:0]  pos_q   [NUM_CHANNELS];
  logic [POS_W-1:0]  len_q   [NUM_CHANNELS];
  logic [PRIO_W-1:0] prio_q  [NUM_CHANNELS];
  logic [SAVE_W-1:0] saved_q [NUM_CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        sound_q[c] <= '0;
        pos_q[c]   <= '0;
        len_q[c]   <= '0;
        prio_q[c]  <= '0;
        saved_q[c] <= '0;
      end
    end else if (wr_i.en) begin
      unique case (wr_i.op)
        TW_PLAY: begin
          sound_q[wr_i.addr] <= wr_i.sound;
          pos_q[wr_i.addr]   <= '0;
          len_q[wr_i.addr]   <= wr_i.len;
          prio_q[wr_i.addr]  <= wr_i.prio;
        end
        TW_ADV: begin
          pos_q[wr_i.addr] <= wr_i.pos;
        end
        TW_CLEAR: begin
          pos_q[wr_i.addr] <= '0;
          len_q[wr_i.addr] <= '0;
        end
        TW_SAVE: begin
          saved_q[wr_i.addr] <= {prio_q[wr_i.addr], len_q[wr_i.addr],
                                 pos_q[wr_i.addr], sound_q[wr_i.addr]};
          pos_q[wr_i.addr]   <= '0;
          len_q[wr_i.addr]   <= '0;
        end
        TW_RESTORE: begin
          sound_q[wr_i.addr] <= saved_q[wr_i.addr][SND_W-1:0];
          pos_q[wr_i.addr]   <= saved_q[wr_i.addr][SND_W+POS_W-1:SND_W];
          len_q[wr_i.addr]   <= saved_q[wr_i.addr][SND_W+2*POS_W-1:SND_W+POS_W];
          prio_q[wr_i.addr]  <= saved_q[wr_i.addr][SAVE_W-1:SAVE_W-PRIO_W];
        end
        default: ;
      endcase
    end
  end

  assign rd_o.sound = sound_q[rd_idx_i];
  assign rd_o.pos   = pos_q[rd_idx_i];
  assign rd_o.len   = len_q[rd_idx_i];
  assign rd_o.prio  = prio_q[rd_idx_i];

endmodule

// File: rtl/core/priority_voice_allocator.sv
// Top level of the priority voice allocator: sequencer, output register and
// the num_sounds register. Depends on pva_pkg, pva_step_unit, pva_chan_table.
//
//   Channel  Signals                          Direction  Moves
//   in       in_valid_i/in_ready_o/in_data_i  input      one request beat
//   out      out_valid_o/out_ready_i/out_data_o output   one result beat
//   cfg      cfg_we_i/cfg_wdata_i             input      num_sounds write
//
// The sequencer walks the channels one per cycle through one shared step unit;
// a tick walk holds on its channel while the output register is full and not taken.
// in_ready_o is high only while the sequencer is idle.
// A full output register that is not taken stalls the sequencer on the beat.
// Reset clears the table, the saved copy and sets num_sounds to 13.
module priority_voice_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pva_pkg::pva_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pva_pkg::pva_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);
  import pva_pkg::*;

  pva_state_e        state_q, state_d;
  pva_in_t           req_q, req_d;
  ch_idx_t           idx_q, idx_d;
  ch_idx_t           pick_q, pick_d;
  logic              found_q, found_d;
  logic              first_q, first_d;
  logic [PRIO_W-1:0] min_val_q, min_val_d;
  logic [POS_W-1:0]  min_diff_q, min_diff_d;
  logic              resp_acc_q, resp_acc_d;
  logic [7:0]        num_sounds_q;
  logic              out_valid_q;
  pva_out_t          out_data_q;

  logic              out_free;
  logic              emit;
  logic              place_ok;
  pva_out_t          emit_data;
  tbl_wr_t           tbl_wr;
  pva_chan_t         chan_rd;
  pva_step_t         step;

  pva_chan_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (tbl_wr),
    .rd_idx_i (idx_q),
    .rd_o     (chan_rd)
  );

  pva_step_unit u_step (
    .chan_i     (chan_rd),
    .tick_i     (req_q.tick_bytes),
    .min_val_i  (min_val_q),
    .min_diff_i (min_diff_q),
    .first_i    (first_q),
    .step_o     (step)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign place_ok   = found_q || (req_q.priority_req >= min_val_q);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    idx_d      = idx_q;
    pick_d     = pick_q;
    found_d    = found_q;
    first_d    = first_q;
    min_val_d  = min_val_q;
    min_diff_d = min_diff_q;
    resp_acc_d = resp_acc_q;
    emit       = 1'b0;
    emit_data  = '0;
    tbl_wr     = '0;
    tbl_wr.op  = TW_PLAY;
    tbl_wr.addr = idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          idx_d   = '0;
          found_d = 1'b0;
          first_d = 1'b1;
          case (in_data_i.op)
            OP_PLAY: begin
              if (in_data_i.sound_id >= num_sounds_q) begin
                resp_acc_d = 1'b0;
                state_d    = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_TICK: state_d = S_TICK;
            OP_CLEAR, OP_SAVE, OP_RESTORE: state_d = S_BULK;
            default: begin
              resp_acc_d = 1'b0;
              state_d    = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (step.left_zero) begin
          // The first finished channel wins outright.
          pick_d  = idx_q;
          found_d = 1'b1;
          state_d = S_PLACE;
        end else begin
          if (step.better) begin
            pick_d     = idx_q;
            min_val_d  = chan_rd.prio;
            min_diff_d = step.left;
            first_d    = 1'b0;
          end
          if (idx_q == LAST_CH) begin
            state_d = S_PLACE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_PLACE: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_data.last = 1'b1;
          if (place_ok) begin
            emit_data.accepted  = 1'b1;
            emit_data.channel   = CHO_W'(pick_q);
            emit_data.out_sound = req_q.sound_id;
            tbl_wr.en    = 1'b1;
            tbl_wr.op    = TW_PLAY;
            tbl_wr.addr  = pick_q;
            tbl_wr.sound = req_q.sound_id;
            tbl_wr.len   = req_q.sound_length;
            tbl_wr.prio  = req_q.priority_req;
          end
          state_d = S_IDLE;
        end
      end
      S_TICK: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_data.accepted      = 1'b1;
          emit_data.channel       = CHO_W'(idx_q);
          emit_data.out_sound     = chan_rd.sound;
          emit_data.read_position = chan_rd.pos;
          emit_data.amount        = step.amount;
          emit_data.last          = (idx_q == LAST_CH);
          tbl_wr.en  = 1'b1;
          tbl_wr.op  = TW_ADV;
          tbl_wr.pos = step.next_pos;
          if (idx_q == LAST_CH) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_BULK: begin
        tbl_wr.en = 1'b1;
        case (req_q.op)
          OP_SAVE:    tbl_wr.op = TW_SAVE;
          OP_RESTORE: tbl_wr.op = TW_RESTORE;
          default:    tbl_wr.op = TW_CLEAR;
        endcase
        if (idx_q == LAST_CH) begin
          resp_acc_d = 1'b1;
          state_d    = S_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          emit               = 1'b1;
          emit_data.accepted = resp_acc_q;
          emit_data.last     = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      pick_q       <= '0;
      found_q      <= 1'b0;
      first_q      <= 1'b1;
      min_val_q    <= '0;
      min_diff_q   <= '0;
      resp_acc_q   <= 1'b0;
      num_sounds_q <= NUM_SOUNDS_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      pick_q     <= pick_d;
      found_q    <= found_d;
      first_q    <= first_d;
      min_val_q  <= min_val_d;
      min_diff_q <= min_diff_d;
      resp_acc_q <= resp_acc_d;
      if (cfg_we_i) begin
        num_sounds_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (emit) begin
      out_data_q <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A new beat never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("result beat overwritten before it was taken");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LAST_CH)
    else $error("channel walk index out of range");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !tbl_wr.en)
    else $error("table written while idle");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_tick_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.op == OP_TICK)) |=>
      ((state_q == S_TICK) && (idx_q == '0)))
    else $error("tick did not start its channel walk at channel zero");

endmodule
